// ===== rtl/core/wsstat_pkg.sv =====
// Shared types, constants and helpers of the windowed sensor statistics unit.
// No dependencies; imported by wsstat_ram users, wsstat_div and the top level.
package wsstat_pkg;

    // Field and state widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int COUNT_WIDTH  = 24;
    localparam int SUM_WIDTH    = SAMPLE_WIDTH + COUNT_WIDTH;
    localparam int TIME_WIDTH   = 32;
    localparam int FLAG_WIDTH   = 32;
    localparam int NUM_CHAN     = 4;
    localparam int CHAN_W       = $clog2(NUM_CHAN);
    localparam int NUM_FAULT    = 3;

    // Fault bit positions
    localparam int FAULT_POWER   = 0;
    localparam int FAULT_COOLING = 1;
    localparam int FAULT_SENSOR  = 2;

    localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(NUM_CHAN - 1);

    // One week in seconds
    localparam logic [TIME_WIDTH-1:0] WINDOW_RESET = TIME_WIDTH'(7 * 24 * 60 * 60);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic        [COUNT_WIDTH-1:0]  t_count;
    typedef logic signed [SUM_WIDTH-1:0]    t_sum;
    typedef logic        [TIME_WIDTH-1:0]   t_time;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Per-channel statistics entry, one word of the channel RAM
    typedef struct packed {
        t_count  count;
        t_sum    sum;
        t_sample min_v;
        t_sample max_v;
    } t_chan_ent;

    localparam t_chan_ent ENT_RESET = '{
        count: '0,
        sum:   '0,
        min_v: SAMPLE_MAX,
        max_v: SAMPLE_MIN
    };

    // Divider request and response
    typedef struct packed {
        logic                 start;
        logic [SUM_WIDTH-1:0] dividend;
        t_count               divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [SUM_WIDTH-1:0] quotient;
    } t_div_rsp;

    // Saturating counter increment
    function automatic t_count sat_inc(input t_count c);
        return (c == '1) ? c : c + t_count'(1);
    endfunction

endpackage

// ===== rtl/core/wsstat_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wsstat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/wsstat_div.sv =====
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on wsstat_pkg (widths, request/response structs).
module wsstat_div import wsstat_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(SUM_WIDTH);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_WIDTH - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [SUM_WIDTH-1:0] r_quo;
    t_count               r_rem;
    t_count               r_div;

    logic [COUNT_WIDTH:0] rem_shift;
    logic [COUNT_WIDTH:0] rem_diff;
    logic                 q_bit;

    // One trial subtraction per cycle
    always_comb begin
        rem_shift = {r_rem, r_quo[SUM_WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, r_div};
        q_bit     = (rem_shift >= {1'b0, r_div});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= q_bit ? rem_diff[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
            r_quo <= {r_quo[SUM_WIDTH-2:0], q_bit};
        end else if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/core/windowed_sensor_statistics_unit.sv =====
// Windowed sensor statistics unit: per-channel sum/min/max/count in a 4-entry RAM.
// Sample transaction: accept, then read and write back each channel.
// Report transaction: 4 results, each a RAM read, load and 40-step serial
// divide plus output wait; one transaction is in flight at a time.
// Synchronous active-low reset restores the cleared statistics and the week window.
// Depends on wsstat_pkg, wsstat_ram, wsstat_div.
module windowed_sensor_statistics_unit import wsstat_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [TIME_WIDTH-1:0]   i_cfg_wdata,
    // input channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_cmd,
    input  logic [TIME_WIDTH-1:0]   i_timestamp,
    input  logic                    i_clock_synced,
    input  logic signed [SAMPLE_WIDTH-1:0] i_current_value,
    input  logic signed [SAMPLE_WIDTH-1:0] i_inlet_temp,
    input  logic signed [SAMPLE_WIDTH-1:0] i_outlet_temp,
    input  logic signed [SAMPLE_WIDTH-1:0] i_temp_delta,
    input  logic [NUM_CHAN-1:0]     i_valid_mask,
    input  logic                    i_power_fault,
    input  logic                    i_cooling_fault,
    input  logic                    i_sensor_ok,
    input  logic [FLAG_WIDTH-1:0]   i_sensor_error_flags,
    // output channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [CHAN_W-1:0]       o_channel,
    output logic [COUNT_WIDTH-1:0]  o_valid_count,
    output logic signed [SAMPLE_WIDTH-1:0] o_average,
    output logic signed [SAMPLE_WIDTH-1:0] o_minimum,
    output logic signed [SAMPLE_WIDTH-1:0] o_maximum,
    output logic [COUNT_WIDTH-1:0]  o_total_samples,
    output logic [COUNT_WIDTH-1:0]  o_power_events,
    output logic [COUNT_WIDTH-1:0]  o_cooling_events,
    output logic [COUNT_WIDTH-1:0]  o_sensor_events,
    output logic [TIME_WIDTH-1:0]   o_window_start,
    output logic [TIME_WIDTH-1:0]   o_last_sample_time,
    output logic                    o_last
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SRD   = 6'b000010,
        S_SUPD  = 6'b000100,
        S_RRD   = 6'b001000,
        S_RLOAD = 6'b010000,
        S_RDIV  = 6'b100000
    } t_state_core;

    typedef enum logic [1:0] {
        O_IDLE = 2'b01,
        O_SEND = 2'b10
    } t_state_out;

    // Control registers
    t_state_core          r_state, n_state;
    t_state_out           r_ostate;
    logic [CHAN_W-1:0]    r_chan;
    logic [NUM_CHAN-1:0]  r_ent_vld;
    logic                 r_clr;
    t_time                r_window_seconds;

    // Global statistics
    t_count               r_total, n_total;
    t_count               r_edges [NUM_FAULT];
    t_count               n_edges [NUM_FAULT];
    t_time                r_begin, n_begin;
    t_time                r_latest, n_latest;
    logic                 r_wsynced, n_wsynced;
    logic                 r_prev_seen, n_prev_seen;
    logic [NUM_FAULT-1:0] r_prev_faults, n_prev_faults;

    // Captured transaction and report payload
    t_sample              r_samp [NUM_CHAN];
    logic [NUM_CHAN-1:0]  r_mask;
    logic                 r_neg;
    t_count               r_ld_count;
    t_sample              r_ld_min;
    t_sample              r_ld_max;
    t_count               r_out_count;
    t_sample              r_out_avg;
    t_sample              r_out_min;
    t_sample              r_out_max;

    logic                 in_acc;
    logic                 out_acc;
    logic                 win_clear;
    t_time                elapsed;
    logic [NUM_FAULT-1:0] cur_faults;

    logic                 ram_we;
    t_chan_ent            ram_wdata;
    logic [$bits(t_chan_ent)-1:0] ram_rdata;
    t_chan_ent            ent_cur;
    t_chan_ent            ent_new;
    t_sample              samp_v;
    t_sample              cur_min;
    t_sample              cur_max;
    t_sum                 sum_abs;
    t_sample              quo_s;

    t_div_req             div_req;
    t_div_rsp             div_rsp;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);

    // Window end test
    always_comb begin
        elapsed   = i_timestamp - r_begin;
        win_clear = (r_begin == '0) ||
                    (i_clock_synced && r_wsynced && (i_timestamp >= r_begin) &&
                     (elapsed >= r_window_seconds));
        cur_faults[FAULT_POWER]   = i_power_fault;
        cur_faults[FAULT_COOLING] = i_cooling_fault;
        cur_faults[FAULT_SENSOR]  = !i_sensor_ok || (i_sensor_error_flags != '0);
    end

    // Global counters and times, updated at sample accept
    always_comb begin
        n_total       = r_total;
        n_begin       = r_begin;
        n_latest      = r_latest;
        n_wsynced     = r_wsynced;
        n_prev_seen   = r_prev_seen;
        n_prev_faults = r_prev_faults;
        for (int k = 0; k < NUM_FAULT; k++) begin
            n_edges[k] = r_edges[k];
        end
        if (in_acc && !i_cmd) begin
            if (win_clear) begin
                n_total       = '0;
                n_begin       = i_timestamp;
                n_wsynced     = 1'b0;
                n_prev_seen   = 1'b0;
                n_prev_faults = '0;
                for (int k = 0; k < NUM_FAULT; k++) begin
                    n_edges[k] = '0;
                end
            end
            n_total  = sat_inc(n_total);
            n_latest = i_timestamp;
            if (i_clock_synced) begin
                n_wsynced = 1'b1;
            end
            if (n_prev_seen) begin
                for (int k = 0; k < NUM_FAULT; k++) begin
                    if (cur_faults[k] && !n_prev_faults[k]) begin
                        n_edges[k] = sat_inc(n_edges[k]);
                    end
                end
            end
            n_prev_seen   = 1'b1;
            n_prev_faults = cur_faults;
        end
    end

    // Channel entry read-modify-write
    always_comb begin
        ent_cur = (r_ent_vld[r_chan] && !r_clr) ? t_chan_ent'(ram_rdata) : ENT_RESET;
        samp_v  = r_samp[r_chan];
        cur_min = ent_cur.min_v;
        cur_max = ent_cur.max_v;
        ent_new = ent_cur;
        if (r_mask[r_chan]) begin
            if (ent_cur.count != '1) begin
                ent_new.sum   = ent_cur.sum +
                    {{(SUM_WIDTH-SAMPLE_WIDTH){samp_v[SAMPLE_WIDTH-1]}}, samp_v};
                ent_new.count = ent_cur.count + t_count'(1);
            end
            if (samp_v < cur_min) begin
                ent_new.min_v = samp_v;
            end
            if (samp_v > cur_max) begin
                ent_new.max_v = samp_v;
            end
        end
        ram_we    = (r_state == S_SUPD);
        ram_wdata = ent_new;
    end

    // Divider request: magnitude of the sum over the count
    always_comb begin
        sum_abs          = ent_cur.sum[SUM_WIDTH-1] ? -ent_cur.sum : ent_cur.sum;
        div_req.start    = (r_state == S_RLOAD);
        div_req.dividend = sum_abs;
        div_req.divisor  = ent_cur.count;
        quo_s            = div_rsp.quotient[SAMPLE_WIDTH-1:0];
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = i_cmd ? S_RRD : S_SRD;
                end
            end
            S_SRD: begin
                n_state = S_SUPD;
            end
            S_SUPD: begin
                n_state = (r_chan == CHAN_LAST) ? S_IDLE : S_SRD;
            end
            S_RRD: begin
                if (r_ostate == O_IDLE) begin
                    n_state = S_RLOAD;
                end
            end
            S_RLOAD: begin
                n_state = S_RDIV;
            end
            S_RDIV: begin
                if (div_rsp.done) begin
                    n_state = S_RRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // Report ends once the last result leaves
        if (r_state == S_RRD && r_ostate == O_SEND && out_acc && o_last) begin
            n_state = S_IDLE;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_ostate         <= O_IDLE;
            r_chan           <= '0;
            r_ent_vld        <= '0;
            r_clr            <= 1'b0;
            r_window_seconds <= WINDOW_RESET;
            r_total          <= '0;
            r_begin          <= '0;
            r_latest         <= '0;
            r_wsynced        <= 1'b0;
            r_prev_seen      <= 1'b0;
            r_prev_faults    <= '0;
            for (int k = 0; k < NUM_FAULT; k++) begin
                r_edges[k] <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_total       <= n_total;
            r_begin       <= n_begin;
            r_latest      <= n_latest;
            r_wsynced     <= n_wsynced;
            r_prev_seen   <= n_prev_seen;
            r_prev_faults <= n_prev_faults;
            for (int k = 0; k < NUM_FAULT; k++) begin
                r_edges[k] <= n_edges[k];
            end
            if (i_cfg_we) begin
                r_window_seconds <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_chan <= '0;
                r_clr  <= !i_cmd && win_clear;
            end
            if (r_state == S_SUPD) begin
                r_ent_vld[r_chan] <= 1'b1;
                if (r_chan != CHAN_LAST) begin
                    r_chan <= r_chan + CHAN_W'(1);
                end
            end
            // Output register handshake
            unique case (r_ostate)
                O_IDLE: begin
                    if (r_state == S_RDIV && div_rsp.done) begin
                        r_ostate <= O_SEND;
                    end
                end
                O_SEND: begin
                    if (out_acc) begin
                        r_ostate <= O_IDLE;
                        if (!o_last) begin
                            r_chan <= r_chan + CHAN_W'(1);
                        end
                    end
                end
                default: begin
                    r_ostate <= O_IDLE;
                end
            endcase
        end
    end

    // Payload capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_samp[0] <= i_current_value;
            r_samp[1] <= i_inlet_temp;
            r_samp[2] <= i_outlet_temp;
            r_samp[3] <= i_temp_delta;
            r_mask    <= i_valid_mask;
        end
        if (r_state == S_RLOAD) begin
            r_neg      <= ent_cur.sum[SUM_WIDTH-1];
            r_ld_count <= ent_cur.count;
            r_ld_min   <= ent_cur.min_v;
            r_ld_max   <= ent_cur.max_v;
        end
        if (r_state == S_RDIV && div_rsp.done) begin
            r_out_count <= r_ld_count;
            if (r_ld_count == '0) begin
                r_out_avg <= '0;
                r_out_min <= '0;
                r_out_max <= '0;
            end else begin
                r_out_avg <= r_neg ? -quo_s : quo_s;
                r_out_min <= r_ld_min;
                r_out_max <= r_ld_max;
            end
        end
    end

    wsstat_ram #(
        .WIDTH ($bits(t_chan_ent)),
        .DEPTH (NUM_CHAN)
    ) u_chan_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_chan),
        .i_wdata (ram_wdata),
        .i_raddr (r_chan),
        .o_rdata (ram_rdata)
    );

    wsstat_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Output ports
    assign o_valid            = (r_ostate == O_SEND);
    assign o_channel          = r_chan;
    assign o_last             = (r_chan == CHAN_LAST);
    assign o_valid_count      = r_out_count;
    assign o_average          = r_out_avg;
    assign o_minimum          = r_out_min;
    assign o_maximum          = r_out_max;
    assign o_total_samples    = r_total;
    assign o_power_events     = r_edges[FAULT_POWER];
    assign o_cooling_events   = r_edges[FAULT_COOLING];
    assign o_sensor_events    = r_edges[FAULT_SENSOR];
    assign o_window_start     = r_begin;
    assign o_last_sample_time = r_latest;

    // Assertions
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result pending while input channel open");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_RDIV))
        else $error("divider finished outside divide state");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last) |=> !o_stall)
        else $error("block not idle after final result");

    a_begin_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_cmd && i_timestamp != '0) |=> (r_begin != '0))
        else $error("window start unset after timed sample");

endmodule
